FILE: sv/joystick_axis_to_motion_command_assert.svh
// assertion macros used by the joystick motion command back end
`ifndef JOYSTICK_AXIS_TO_MOTION_COMMAND_ASSERT_SVH
`define JOYSTICK_AXIS_TO_MOTION_COMMAND_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define JAMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define JAMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/jamc_pkg.sv
// shared types and constants of the joystick motion command block
package jamc_pkg;

    localparam int ADC_BITS   = 10;
    localparam int OUT_W      = 11;
    localparam int OMAX_W     = 10;
    localparam int SPEED_W    = 10;
    localparam int DX_W       = ADC_BITS + 1;
    localparam int DR_W       = OUT_W + 1;
    localparam int NUM_W      = ADC_BITS + OUT_W;
    localparam int SUM_W      = NUM_W + 2;
    localparam int CNT_W      = $clog2(NUM_W + 1);
    localparam int OUT_LIMIT  = 1023;
    localparam int IN_W       = ((3 * ADC_BITS + 1 + 7) / 8) * 8;
    localparam int OUTD_W     = 16;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int NUM_AXES   = 3;
    localparam int PADDR_W    = 5;

    localparam logic [1:0] AXIS_A_X = 2'd0;
    localparam logic [1:0] AXIS_A_Y = 2'd1;
    localparam logic [1:0] AXIS_B_Y = 2'd2;

    localparam logic [2:0] REG_ADC_MIN    = 3'd0;
    localparam logic [2:0] REG_ADC_CENTRE = 3'd1;
    localparam logic [2:0] REG_ADC_MAX    = 3'd2;
    localparam logic [2:0] REG_DEAD_LOW   = 3'd3;
    localparam logic [2:0] REG_DEAD_HIGH  = 3'd4;
    localparam logic [2:0] REG_OUT_MIN    = 3'd5;
    localparam logic [2:0] REG_OUT_CENTRE = 3'd6;
    localparam logic [2:0] REG_OUT_MAX    = 3'd7;

    typedef enum logic [2:0] {
        DIR_STOP,
        DIR_FORWARD,
        DIR_BACKWARD,
        DIR_LEFT,
        DIR_RIGHT,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_ACC,
        B_DECIDE
    } back_state_t;

    typedef struct packed {
        logic [ADC_BITS-1:0]     adc_min;
        logic [ADC_BITS-1:0]     adc_centre;
        logic [ADC_BITS-1:0]     adc_max;
        logic [ADC_BITS-1:0]     dead_low;
        logic [ADC_BITS-1:0]     dead_high;
        logic signed [OUT_W-1:0] out_min;
        logic signed [OUT_W-1:0] out_centre;
        logic [OMAX_W-1:0]       out_max;
    } cfg_t;

    // one axis reduced to the terms of its segment map
    typedef struct packed {
        logic signed [DX_W-1:0]  dx;
        logic signed [DR_W-1:0]  dr;
        logic signed [DX_W-1:0]  den;
        logic signed [OUT_W-1:0] olo;
        logic                    empty;
    } axis_job_t;

    typedef struct packed {
        axis_job_t [NUM_AXES-1:0] axes;
        logic                     button;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: sv/joystick_axis_to_motion_command.sv
// the back end takes one word at a time through the 21-step serial divider, once per axis
// a two-word queue lets the input side take words while the back end is busy
// the result register holds a word until taken and the next one is computed meanwhile
// reset: asynchronous active-low, clears held axes, direction, speed, toggles, the queue
// and the output valid, and sets the configuration registers to their defaults
module joystick_axis_to_motion_command (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jamc_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // stick_a_x, stick_a_y, stick_b_y, button_a, zero pad
    input  logic [jamc_pkg::IN_W-1:0]       s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // changed, direction[2:0], speed[9:0], toggle_a, toggle_b
    output logic [jamc_pkg::OUTD_W-1:0]     m_tdata
);

    localparam int AB = jamc_pkg::ADC_BITS;

    jamc_pkg::cfg_t       cfg_reg;
    jamc_pkg::fifo_stat_t fifo_stat;
    jamc_pkg::job_t       job_in;
    jamc_pkg::job_t       job_out;
    logic                 push;
    logic                 pop;
    logic                 wr_en;
    logic [2:0]           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[jamc_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_min    <= '0;
            cfg_reg.adc_centre <= AB'(512);
            cfg_reg.adc_max    <= AB'(1023);
            cfg_reg.dead_low   <= AB'(500);
            cfg_reg.dead_high  <= AB'(524);
            cfg_reg.out_min    <= -jamc_pkg::OUT_W'(255);
            cfg_reg.out_centre <= '0;
            cfg_reg.out_max    <= jamc_pkg::OMAX_W'(255);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                jamc_pkg::REG_ADC_MIN:    cfg_reg.adc_min    <= pwdata[AB-1:0];
                jamc_pkg::REG_ADC_CENTRE: cfg_reg.adc_centre <= pwdata[AB-1:0];
                jamc_pkg::REG_ADC_MAX:    cfg_reg.adc_max    <= pwdata[AB-1:0];
                jamc_pkg::REG_DEAD_LOW:   cfg_reg.dead_low   <= pwdata[AB-1:0];
                jamc_pkg::REG_DEAD_HIGH:  cfg_reg.dead_high  <= pwdata[AB-1:0];
                jamc_pkg::REG_OUT_MIN:    cfg_reg.out_min    <= pwdata[jamc_pkg::OUT_W-1:0];
                jamc_pkg::REG_OUT_CENTRE: cfg_reg.out_centre <= pwdata[jamc_pkg::OUT_W-1:0];
                jamc_pkg::REG_OUT_MAX:    cfg_reg.out_max    <= pwdata[jamc_pkg::OMAX_W-1:0];
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            jamc_pkg::REG_ADC_MIN:    prdata = 32'(cfg_reg.adc_min);
            jamc_pkg::REG_ADC_CENTRE: prdata = 32'(cfg_reg.adc_centre);
            jamc_pkg::REG_ADC_MAX:    prdata = 32'(cfg_reg.adc_max);
            jamc_pkg::REG_DEAD_LOW:   prdata = 32'(cfg_reg.dead_low);
            jamc_pkg::REG_DEAD_HIGH:  prdata = 32'(cfg_reg.dead_high);
            jamc_pkg::REG_OUT_MIN:    prdata = {21'b0, cfg_reg.out_min};
            jamc_pkg::REG_OUT_CENTRE: prdata = {21'b0, cfg_reg.out_centre};
            jamc_pkg::REG_OUT_MAX:    prdata = 32'(cfg_reg.out_max);
            default:                  prdata = '0;
        endcase
    end

    jamc_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg_reg),
        .fifo_stat (fifo_stat),
        .push      (push),
        .job       (job_in)
    );

    jamc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .job_out (job_out),
        .stat    (fifo_stat)
    );

    jamc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_stat  (fifo_stat),
        .job        (job_out),
        .pop        (pop),
        .out_centre (cfg_reg.out_centre),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: sv/jamc_front.sv
// front end: takes sample words, applies deadband and picks the map segment
module jamc_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // stick_a_x, stick_a_y, stick_b_y, button_a, zero pad
    input  logic [jamc_pkg::IN_W-1:0] s_tdata,
    input  jamc_pkg::cfg_t            cfg,
    input  jamc_pkg::fifo_stat_t      fifo_stat,
    output logic                      push,
    output jamc_pkg::job_t            job
);

    localparam int AB = jamc_pkg::ADC_BITS;

    function automatic jamc_pkg::axis_job_t classify(
        input logic [jamc_pkg::ADC_BITS-1:0] raw_in,
        input jamc_pkg::cfg_t                c
    );
        logic [jamc_pkg::ADC_BITS-1:0]     r;
        logic [jamc_pkg::ADC_BITS-1:0]     in_lo;
        logic [jamc_pkg::ADC_BITS-1:0]     in_hi;
        logic signed [jamc_pkg::OUT_W-1:0] o_lo;
        logic signed [jamc_pkg::DR_W-1:0]  o_hi;
        jamc_pkg::axis_job_t               a;
        r = raw_in;
        if (r < c.dead_high && r > c.dead_low)
        begin
            r = c.adc_centre;
        end
        if (r >= c.adc_centre)
        begin
            in_lo = c.adc_centre;
            in_hi = c.adc_max;
            o_lo  = c.out_centre;
            o_hi  = $signed({2'b00, c.out_max});
        end
        else
        begin
            in_lo = c.adc_min;
            in_hi = c.adc_centre;
            o_lo  = c.out_min;
            o_hi  = jamc_pkg::DR_W'(c.out_centre);
        end
        a.dx    = $signed({1'b0, r}) - $signed({1'b0, in_lo});
        a.den   = $signed({1'b0, in_hi}) - $signed({1'b0, in_lo});
        a.dr    = o_hi - jamc_pkg::DR_W'(o_lo);
        a.olo   = o_lo;
        a.empty = (in_hi == in_lo);
        return a;
    endfunction

    assign s_tready = !fifo_stat.full;
    assign push     = s_tvalid && !fifo_stat.full;

    always_comb
    begin
        job.axes[jamc_pkg::AXIS_A_X] = classify(s_tdata[AB-1:0], cfg);
        job.axes[jamc_pkg::AXIS_A_Y] = classify(s_tdata[2*AB-1:AB], cfg);
        job.axes[jamc_pkg::AXIS_B_Y] = classify(s_tdata[3*AB-1:2*AB], cfg);
        job.button                   = s_tdata[3*AB];
    end

endmodule

FILE: sv/jamc_fifo.sv
// short job queue between front end and back end
module jamc_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jamc_pkg::job_t       job_in,
    input  logic                 pop,
    output jamc_pkg::job_t       job_out,
    output jamc_pkg::fifo_stat_t stat
);

    jamc_pkg::job_t                 mem_reg [jamc_pkg::FIFO_DEPTH];
    logic [jamc_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [jamc_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [jamc_pkg::FIFO_CW-1:0]   count_reg, count_next;

    localparam logic [jamc_pkg::FIFO_AW-1:0] PTR_LAST =
        jamc_pkg::FIFO_AW'(jamc_pkg::FIFO_DEPTH - 1);
    localparam logic [jamc_pkg::FIFO_CW-1:0] CNT_FULL =
        jamc_pkg::FIFO_CW'(jamc_pkg::FIFO_DEPTH);

    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);
    assign job_out    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

FILE: sv/jamc_back.sv
// back end: serial multiply-divide per axis, then direction, speed and toggles
`include "joystick_axis_to_motion_command_assert.svh"

module jamc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  jamc_pkg::fifo_stat_t          fifo_stat,
    input  jamc_pkg::job_t                job,
    output logic                          pop,
    input  logic signed [jamc_pkg::OUT_W-1:0] out_centre,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // changed, direction[2:0], speed[9:0], toggle_a, toggle_b
    output logic [jamc_pkg::OUTD_W-1:0]   m_tdata
);

    localparam int AB    = jamc_pkg::ADC_BITS;
    localparam int NW    = jamc_pkg::NUM_W;
    localparam int SW    = jamc_pkg::SUM_W;
    localparam int OW    = jamc_pkg::OUT_W;
    localparam int CW    = jamc_pkg::CNT_W;
    localparam logic signed [SW-1:0] LIM_POS = SW'(jamc_pkg::OUT_LIMIT);
    localparam logic signed [SW-1:0] LIM_NEG = -SW'(jamc_pkg::OUT_LIMIT);
    localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);

    jamc_pkg::back_state_t state_reg, state_next;

    jamc_pkg::job_t        job_reg;
    logic [1:0]            idx_reg;
    logic [NW-1:0]         quo_reg;
    logic [AB-1:0]         rem_reg;
    logic [AB-1:0]         den_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  neg_reg;
    logic                  empty_reg;
    logic signed [OW-1:0]  olo_reg;
    logic signed [OW-1:0]  mapped_reg [jamc_pkg::NUM_AXES];

    logic signed [OW-1:0]  last_ax_reg, last_ay_reg, last_by_reg;
    logic                  last_button_reg;
    jamc_pkg::dir_t        dir_reg, dir_next;
    logic [jamc_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic                  flag_a_reg, flag_b_reg;
    logic                  m_tvalid_reg;
    logic [jamc_pkg::OUTD_W-1:0] m_tdata_reg;

    jamc_pkg::axis_job_t   cur;
    logic signed [NW:0]    prod;
    logic signed [jamc_pkg::DX_W-1:0] den_abs;
    logic [AB:0]           rem_shift;
    logic [AB:0]           rem_trial;
    logic                  q_bit;
    logic signed [SW-1:0]  q_signed;
    logic signed [SW-1:0]  sum;
    logic signed [OW-1:0]  sat_val;
    logic                  load;
    logic                  axes_changed;
    logic                  btn_rise;
    logic                  changed;
    logic signed [OW-1:0]  ax, ay, by;
    logic signed [OW-1:0]  sel_val;

    function automatic logic [jamc_pkg::SPEED_W-1:0] mag(
        input logic signed [jamc_pkg::OUT_W-1:0] v
    );
        logic signed [jamc_pkg::OUT_W-1:0] n;
        n = v[jamc_pkg::OUT_W-1] ? -v : v;
        return n[jamc_pkg::SPEED_W-1:0];
    endfunction

    // datapath terms
    always_comb
    begin
        cur     = job_reg.axes[idx_reg];
        prod    = (NW + 1)'(cur.dx) * (NW + 1)'(cur.dr);
        den_abs = cur.den[jamc_pkg::DX_W-1] ? -cur.den : cur.den;

        rem_shift = {rem_reg, quo_reg[NW-1]};
        rem_trial = rem_shift - {1'b0, den_reg};
        q_bit     = (rem_shift >= {1'b0, den_reg});

        q_signed = $signed({2'b00, quo_reg});
        if (neg_reg)
        begin
            q_signed = -q_signed;
        end
        sum = q_signed + SW'(olo_reg);
        priority if (empty_reg)
        begin
            sat_val = out_centre;
        end
        else if (sum > LIM_POS)
        begin
            sat_val = OW'(jamc_pkg::OUT_LIMIT);
        end
        else if (sum < LIM_NEG)
        begin
            sat_val = -OW'(jamc_pkg::OUT_LIMIT);
        end
        else
        begin
            sat_val = sum[OW-1:0];
        end
    end

    // direction and speed by fixed axis priority
    always_comb
    begin
        ax = mapped_reg[jamc_pkg::AXIS_A_X];
        ay = mapped_reg[jamc_pkg::AXIS_A_Y];
        by = mapped_reg[jamc_pkg::AXIS_B_Y];
        axes_changed = (ax != last_ax_reg) || (ay != last_ay_reg) || (by != last_by_reg);
        btn_rise     = job_reg.button && !last_button_reg;
        changed      = axes_changed || btn_rise;
        sel_val      = '0;
        priority if (ay < out_centre)
        begin
            dir_next = jamc_pkg::DIR_FORWARD;
            sel_val  = ay;
        end
        else if (ay > out_centre)
        begin
            dir_next = jamc_pkg::DIR_BACKWARD;
            sel_val  = ay;
        end
        else if (ax < out_centre)
        begin
            dir_next = jamc_pkg::DIR_LEFT;
            sel_val  = ax;
        end
        else if (ax > out_centre)
        begin
            dir_next = jamc_pkg::DIR_RIGHT;
            sel_val  = ax;
        end
        else if (by < out_centre)
        begin
            dir_next = jamc_pkg::DIR_UP;
            sel_val  = by;
        end
        else if (by > out_centre)
        begin
            dir_next = jamc_pkg::DIR_DOWN;
            sel_val  = by;
        end
        else
        begin
            dir_next = jamc_pkg::DIR_STOP;
        end
        speed_next = mag(sel_val);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jamc_pkg::B_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    state_next = jamc_pkg::B_MUL;
                end
            end
            jamc_pkg::B_MUL:
            begin
                state_next = jamc_pkg::B_DIV;
            end
            jamc_pkg::B_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = jamc_pkg::B_ACC;
                end
            end
            jamc_pkg::B_ACC:
            begin
                state_next = (idx_reg == jamc_pkg::AXIS_B_Y) ? jamc_pkg::B_DECIDE
                                                             : jamc_pkg::B_MUL;
            end
            jamc_pkg::B_DECIDE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = jamc_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = jamc_pkg::B_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            jamc_pkg::B_IDLE:
            begin
                pop = !fifo_stat.empty;
            end
            jamc_pkg::B_DECIDE:
            begin
                load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                pop  = 1'b0;
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= jamc_pkg::B_IDLE;
            last_ax_reg     <= '0;
            last_ay_reg     <= '0;
            last_by_reg     <= '0;
            last_button_reg <= 1'b0;
            dir_reg         <= jamc_pkg::DIR_STOP;
            speed_reg       <= '0;
            flag_a_reg      <= 1'b0;
            flag_b_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                m_tvalid_reg    <= 1'b1;
                last_button_reg <= job_reg.button;
                if (axes_changed)
                begin
                    last_ax_reg <= ax;
                    last_ay_reg <= ay;
                    last_by_reg <= by;
                    dir_reg     <= dir_next;
                    speed_reg   <= speed_next;
                end
                if (btn_rise)
                begin
                    flag_a_reg <= !flag_a_reg;
                    flag_b_reg <= !flag_b_reg;
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            jamc_pkg::B_IDLE:
            begin
                job_reg <= job;
                idx_reg <= jamc_pkg::AXIS_A_X;
            end
            jamc_pkg::B_MUL:
            begin
                quo_reg   <= prod[NW] ? NW'(-prod) : NW'(prod);
                den_reg   <= den_abs[AB-1:0];
                neg_reg   <= prod[NW] ^ cur.den[jamc_pkg::DX_W-1];
                empty_reg <= cur.empty;
                olo_reg   <= cur.olo;
                rem_reg   <= '0;
                cnt_reg   <= '0;
            end
            jamc_pkg::B_DIV:
            begin
                // restoring division, one quotient bit a cycle
                rem_reg <= q_bit ? rem_trial[AB-1:0] : rem_shift[AB-1:0];
                quo_reg <= {quo_reg[NW-2:0], q_bit};
                cnt_reg <= cnt_reg + 1'b1;
            end
            jamc_pkg::B_ACC:
            begin
                mapped_reg[idx_reg] <= sat_val;
                idx_reg             <= idx_reg + 1'b1;
            end
            jamc_pkg::B_DECIDE:
            begin
                if (load)
                begin
                    m_tdata_reg <= {flag_b_reg ^ btn_rise, flag_a_reg ^ btn_rise,
                                    axes_changed ? speed_next : speed_reg,
                                    axes_changed ? dir_next : dir_reg,
                                    changed};
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `JAMC_ASSERT_IMP(a_div_count, state_reg == jamc_pkg::B_DIV, cnt_reg <= CNT_LAST, "divider ran past its last step")
    `JAMC_ASSERT_IMP(a_pop_idle, pop, state_reg == jamc_pkg::B_IDLE && !fifo_stat.empty, "queue popped outside idle or while empty")
    `JAMC_ASSERT_IMP(a_acc_axis, state_reg == jamc_pkg::B_ACC, idx_reg <= jamc_pkg::AXIS_B_Y, "axis index out of range")
    `JAMC_ASSERT_NXT(a_decide_out, load, m_tvalid_reg && state_reg == jamc_pkg::B_IDLE, "result not presented after decide")

endmodule

FILE: bench/jamc_motion_checker.sv
// checker for the joystick motion command block: tracks registers, predicts and compares words
module jamc_motion_checker
    import jamc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUTD_W-1:0]     m_tdata,
    output int unsigned           pending,
    output int unsigned           checked,
    output int unsigned           failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               changed;
        dir_t               direction;
        logic [SPEED_W-1:0] speed;
        logic               toggle_a;
        logic               toggle_b;
    } motion_cmd_t;

    // register copy, kept from observed writes
    logic [ADC_BITS-1:0]     adc_min, adc_centre, adc_max, dead_low, dead_high;
    logic signed [OUT_W-1:0] out_min, out_centre;
    logic [OMAX_W-1:0]       out_max;

    // held motion state
    int                 last_ax, last_ay, last_by;
    logic               last_btn;
    dir_t               held_dir;
    logic [SPEED_W-1:0] held_speed;
    logic               flag_a, flag_b;

    motion_cmd_t pending_cmds[$];
    int unsigned n_checked;
    int unsigned n_failed;

    function automatic int segment_map(int x, int in_lo, int in_hi, int o_lo, int o_hi);
        int r;
        if (in_hi == in_lo)
            return int'(out_centre);
        r = (x - in_lo) * (o_hi - o_lo) / (in_hi - in_lo) + o_lo;
        if (r > OUT_LIMIT)
            r = OUT_LIMIT;
        if (r < -OUT_LIMIT)
            r = -OUT_LIMIT;
        return r;
    endfunction

    function automatic int axis_value(logic [ADC_BITS-1:0] raw);
        logic [ADC_BITS-1:0] r;
        r = raw;
        if (r < dead_high && r > dead_low)
            r = adc_centre;
        if (r >= adc_centre)
            return segment_map(int'(r), int'(adc_centre), int'(adc_max),
                               int'(out_centre), int'(out_max));
        return segment_map(int'(r), int'(adc_min), int'(adc_centre),
                           int'(out_min), int'(out_centre));
    endfunction

    function automatic logic [SPEED_W-1:0] magnitude(int v);
        return SPEED_W'((v < 0) ? -v : v);
    endfunction

    task automatic predict_command(input logic [IN_W-1:0] w);
        int          ax, ay, by, oc;
        logic        btn;
        motion_cmd_t cmd;
        ax  = axis_value(w[ADC_BITS-1:0]);
        ay  = axis_value(w[2*ADC_BITS-1:ADC_BITS]);
        by  = axis_value(w[3*ADC_BITS-1:2*ADC_BITS]);
        btn = w[3*ADC_BITS];
        oc  = int'(out_centre);
        cmd.changed = 1'b0;
        if (ax != last_ax || ay != last_ay || by != last_by)
        begin
            cmd.changed = 1'b1;
            last_ax = ax;
            last_ay = ay;
            last_by = by;
            // fixed priority: stick A vertical, then A horizontal, then B vertical
            if (ay < oc)
            begin
                held_dir = DIR_FORWARD;  held_speed = magnitude(ay);
            end
            else if (ay > oc)
            begin
                held_dir = DIR_BACKWARD; held_speed = magnitude(ay);
            end
            else if (ax < oc)
            begin
                held_dir = DIR_LEFT;     held_speed = magnitude(ax);
            end
            else if (ax > oc)
            begin
                held_dir = DIR_RIGHT;    held_speed = magnitude(ax);
            end
            else if (by < oc)
            begin
                held_dir = DIR_UP;       held_speed = magnitude(by);
            end
            else if (by > oc)
            begin
                held_dir = DIR_DOWN;     held_speed = magnitude(by);
            end
            else
            begin
                held_dir = DIR_STOP;     held_speed = '0;
            end
        end
        if (btn && !last_btn)
        begin
            flag_a      = ~flag_a;
            flag_b      = ~flag_b;
            cmd.changed = 1'b1;
        end
        last_btn       = btn;
        cmd.direction  = held_dir;
        cmd.speed      = held_speed;
        cmd.toggle_a   = flag_a;
        cmd.toggle_b   = flag_b;
        pending_cmds.push_back(cmd);
    endtask

    task automatic check_command(input logic [OUTD_W-1:0] w);
        motion_cmd_t want;
        if (pending_cmds.size() == 0)
        begin
            $error("result word %h with no sample outstanding", w);
            n_failed++;
            return;
        end
        want = pending_cmds.pop_front();
        n_checked++;
        if (w[0] !== want.changed)
        begin
            $error("changed mismatch: expected %0d, got %0d", want.changed, w[0]);
            n_failed++;
        end
        if (w[3:1] !== want.direction)
        begin
            $error("direction mismatch: expected %0d, got %0d", want.direction, w[3:1]);
            n_failed++;
        end
        if (w[13:4] !== want.speed)
        begin
            $error("speed mismatch: expected %0d, got %0d", want.speed, w[13:4]);
            n_failed++;
        end
        if (w[14] !== want.toggle_a)
        begin
            $error("toggle_a mismatch: expected %0d, got %0d", want.toggle_a, w[14]);
            n_failed++;
        end
        if (w[15] !== want.toggle_b)
        begin
            $error("toggle_b mismatch: expected %0d, got %0d", want.toggle_b, w[15]);
            n_failed++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_min    = 10'd0;
            adc_centre = 10'd512;
            adc_max    = 10'd1023;
            dead_low   = 10'd500;
            dead_high  = 10'd524;
            out_min    = -11'sd255;
            out_centre = 11'sd0;
            out_max    = 10'd255;
            last_ax    = 0;
            last_ay    = 0;
            last_by    = 0;
            last_btn   = 1'b0;
            held_dir   = DIR_STOP;
            held_speed = '0;
            flag_a     = 1'b0;
            flag_b     = 1'b0;
            n_checked  = 0;
            n_failed   = 0;
            pending_cmds.delete();
            pending  <= 0;
            checked  <= 0;
            failures <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_ADC_MIN:    adc_min    = pwdata[ADC_BITS-1:0];
                    REG_ADC_CENTRE: adc_centre = pwdata[ADC_BITS-1:0];
                    REG_ADC_MAX:    adc_max    = pwdata[ADC_BITS-1:0];
                    REG_DEAD_LOW:   dead_low   = pwdata[ADC_BITS-1:0];
                    REG_DEAD_HIGH:  dead_high  = pwdata[ADC_BITS-1:0];
                    REG_OUT_MIN:    out_min    = pwdata[OUT_W-1:0];
                    REG_OUT_CENTRE: out_centre = pwdata[OUT_W-1:0];
                    REG_OUT_MAX:    out_max    = pwdata[OMAX_W-1:0];
                    default: ;
                endcase
            end
            // sample side first so a word taken on this edge is queued before any compare
            if (s_tvalid && s_tready)
                predict_command(s_tdata);
            if (m_tvalid && m_tready)
                check_command(m_tdata);
            pending  <= pending_cmds.size();
            checked  <= n_checked;
            failures <= n_failed;
        end
    end

endmodule

FILE: bench/tb_joystick_axis_to_motion_command.sv
// testbench top for the joystick motion command block: clock, reset, stimulus and verdict
module tb_joystick_axis_to_motion_command;
    timeunit 1ns;
    timeprecision 1ps;

    import jamc_pkg::*;

    localparam int NUM_PHASES     = 9;
    localparam int SAMPLES_PER_PH = 75;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 100;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    // stick_a_x, stick_a_y, stick_b_y, button_a, zero pad
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // changed, direction[2:0], speed[9:0], toggle_a, toggle_b
    logic [OUTD_W-1:0]   m_tdata;

    int unsigned pending, checked, failures;

    cfg_t                cur;
    logic [ADC_BITS-1:0] prev_ax, prev_ay, prev_by;
    logic                btn_level;
    int unsigned         burst_left;
    bit                  gaps_on;
    int unsigned         samples_sent;
    int unsigned         quiet_cycles = 0;
    int unsigned         ready_hold;

    joystick_axis_to_motion_command u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    jamc_motion_checker u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .pending  (pending),
        .checked  (checked),
        .failures (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: long free stretches, solid stalls and choppy stretches
    initial
    begin
        m_tready   = 1'b0;
        ready_hold = 0;
        forever
        begin
            @(negedge clk);
            if (ready_hold == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        m_tready  <= 1'b1;
                        ready_hold = $urandom_range(50, 300);
                    end
                    1:
                    begin
                        m_tready  <= 1'b0;
                        ready_hold = $urandom_range(1, 40);
                    end
                    default:
                    begin
                        m_tready  <= 1'($urandom_range(0, 1));
                        ready_hold = $urandom_range(0, 6);
                    end
                endcase
            end
            else
                ready_hold--;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles, %0d words outstanding",
                     quiet_cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic cfg_t make_cfg(int mn, int ce, int mx, int dl, int dh,
                                      int omn, int oce, int omx);
        cfg_t c;
        c.adc_min    = ADC_BITS'(mn);
        c.adc_centre = ADC_BITS'(ce);
        c.adc_max    = ADC_BITS'(mx);
        c.dead_low   = ADC_BITS'(dl);
        c.dead_high  = ADC_BITS'(dh);
        c.out_min    = OUT_W'(omn);
        c.out_centre = OUT_W'(oce);
        c.out_max    = OMAX_W'(omx);
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        return make_cfg($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), -int'($urandom_range(0, 1023)),
                        int'($urandom_range(0, 2046)) - 1023, $urandom_range(0, 1023));
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input cfg_t c);
        reg_write(REG_ADC_MIN,    {22'd0, c.adc_min});
        reg_write(REG_ADC_CENTRE, {22'd0, c.adc_centre});
        reg_write(REG_ADC_MAX,    {22'd0, c.adc_max});
        reg_write(REG_DEAD_LOW,   {22'd0, c.dead_low});
        reg_write(REG_DEAD_HIGH,  {22'd0, c.dead_high});
        reg_write(REG_OUT_MIN,    {21'd0, c.out_min});
        reg_write(REG_OUT_CENTRE, {21'd0, c.out_centre});
        reg_write(REG_OUT_MAX,    {22'd0, c.out_max});
        cur = c;
    endtask

    // hold the sample side off until every result word has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic offer_sample(input logic [ADC_BITS-1:0] ax, input logic [ADC_BITS-1:0] ay,
                                input logic [ADC_BITS-1:0] by, input logic btn);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 90);
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                repeat (gap - 1)
                    @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, btn, by, ay, ax};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        prev_ax   = ax;
        prev_ay   = ay;
        prev_by   = by;
        btn_level = btn;
        samples_sent++;
    endtask

    // raw value biased toward the edges of the current register setting
    function automatic logic [ADC_BITS-1:0] pick_raw();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return cur.dead_low + ADC_BITS'($urandom_range(0, 2)) - 1'b1;
            3:       return cur.dead_high + ADC_BITS'($urandom_range(0, 2)) - 1'b1;
            4:       return cur.adc_centre;
            5:       return cur.adc_min;
            6:       return cur.adc_max;
            7:       return cur.adc_centre + ADC_BITS'($urandom_range(0, 8)) - 3'd4;
            default: return ADC_BITS'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic send_random_sample();
        logic [ADC_BITS-1:0] ax, ay, by;
        logic                btn;
        ax = prev_ax;
        ay = prev_ay;
        by = prev_by;
        // a repeated sample only changes through the button
        if ($urandom_range(0, 5) != 0)
        begin
            ax = pick_raw();
            ay = pick_raw();
            by = pick_raw();
            if ($urandom_range(0, 2) == 0)
                ay = cur.adc_centre;
            if ($urandom_range(0, 3) == 0)
                ax = cur.adc_centre;
        end
        btn = ($urandom_range(0, 2) == 0) ? ~btn_level : btn_level;
        offer_sample(ax, ay, by, btn);
    endtask

    initial
    begin
        cfg_t phase_cfg;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        samples_sent = 0;
        prev_ax      = '0;
        prev_ay      = '0;
        prev_by      = '0;
        btn_level    = 1'b0;
        cur          = make_cfg(0, 512, 1023, 500, 524, -255, 0, 255);
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed samples under the reset register values
        offer_sample(10'd512,  10'd512,  10'd512,  1'b0);
        offer_sample(10'd512,  10'd0,    10'd512,  1'b0);
        offer_sample(10'd512,  10'd1023, 10'd512,  1'b0);
        offer_sample(10'd0,    10'd512,  10'd512,  1'b0);
        offer_sample(10'd1023, 10'd512,  10'd512,  1'b0);
        offer_sample(10'd512,  10'd512,  10'd0,    1'b0);
        offer_sample(10'd512,  10'd512,  10'd1023, 1'b0);
        offer_sample(10'd512,  10'd512,  10'd1023, 1'b0);
        offer_sample(10'd500,  10'd512,  10'd512,  1'b0);
        offer_sample(10'd501,  10'd512,  10'd512,  1'b0);
        offer_sample(10'd523,  10'd512,  10'd512,  1'b0);
        offer_sample(10'd524,  10'd512,  10'd512,  1'b0);
        offer_sample(10'd512,  10'd512,  10'd512,  1'b1);
        offer_sample(10'd512,  10'd512,  10'd512,  1'b1);
        offer_sample(10'd512,  10'd512,  10'd512,  1'b0);
        offer_sample(10'd512,  10'd512,  10'd512,  1'b1);
        offer_sample(10'd0,    10'd0,    10'd0,    1'b1);
        offer_sample(10'd1023, 10'd1023, 10'd1023, 1'b0);
        offer_sample(10'd1023, 10'd1023, 10'd1023, 1'b1);
        offer_sample(10'd0,    10'd1023, 10'd0,    1'b0);
        offer_sample(10'd1023, 10'd511,  10'd513,  1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_cfg = make_cfg(0, 512, 1023, 500, 524, -1023, 0, 1023);
                // upper segment empty
                1: phase_cfg = make_cfg(0, 700, 700, 690, 710, -600, 100, 900);
                // lower segment empty
                2: phase_cfg = make_cfg(300, 300, 1023, 290, 310, -1023, -200, 400);
                // inverted ranges, deadband that can hold nothing
                3: phase_cfg = make_cfg(900, 500, 100, 600, 400, 0, -1023, 0);
                // narrow segments so raw values outside them extrapolate and saturate
                4: phase_cfg = make_cfg(400, 512, 600, 511, 513, -1023, -600, 1023);
                // deadband over nearly the whole range
                5: phase_cfg = make_cfg(0, 512, 1023, 0, 1023, -1023, 1023, 0);
                8: phase_cfg = make_cfg(0, 512, 1023, 500, 524, -255, 0, 255);
                default: phase_cfg = random_cfg();
            endcase
            drain_results();
            apply_settings(phase_cfg);
            gaps_on = (p % 3 != 1);
            for (int i = 0; i < SAMPLES_PER_PH; i++)
            begin
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                send_random_sample();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        $display("covered %0d joystick samples over %0d register settings after the reset values",
                 samples_sent, NUM_PHASES);
        $display("%0d motion command words checked, %0d mismatches", checked, failures);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
